FILE: design/spn_pkg.sv
// Shared types, constants and round functions for the 16-bit SPN cipher.
package spn_pkg;

  localparam int unsigned Rounds    = 8;
  localparam int unsigned BlockW    = 16;
  localparam int unsigned KeyRegs   = 4;
  localparam int unsigned KeyRegW   = 64;
  localparam int unsigned KeysPerReg = KeyRegW / BlockW;
  localparam int unsigned CfgIdxW   = 3;

  typedef logic [BlockW-1:0] block_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode  = 3'd0,
    CfgKeys0 = 3'd1,
    CfgKeys1 = 3'd2,
    CfgKeys2 = 3'd3,
    CfgKeys3 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic   decrypt;
    block_t key;
  } round_cfg_t;

  localparam logic [3:0] SboxFwd [16] = '{
    4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
  };
  localparam logic [3:0] SboxInv [16] = '{
    4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
    4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
  };

  function automatic block_t substitute(block_t x, logic inv);
    block_t y;
    y = '0;
    for (int n = 0; n < 4; n++) begin
      if (inv) begin
        y[4*n +: 4] = SboxInv[x[4*n +: 4]];
      end else begin
        y[4*n +: 4] = SboxFwd[x[4*n +: 4]];
      end
    end
    return y;
  endfunction

  // 4x4 bit transpose, positions counted from the MSB
  function automatic block_t transpose(block_t x);
    block_t y;
    y = '0;
    for (int i = 0; i < 16; i++) begin
      y[15 - (4 * (i % 4) + i / 4)] = x[15 - i];
    end
    return y;
  endfunction

  function automatic block_t round_fn(block_t x, round_cfg_t cfg);
    block_t y;
    if (cfg.decrypt) begin
      y = substitute(transpose(x ^ cfg.key), 1'b1);
    end else begin
      y = transpose(substitute(x, 1'b0)) ^ cfg.key;
    end
    return y;
  endfunction

endpackage

FILE: design/spn_block_cipher_16bit_unit.sv
// Top level: configuration registers and the chain of round cells.
//
// Input channel: in_valid_i / in_stall_o with block_in_i; a request is taken
// at an edge with valid high and stall low. Output channel: out_valid_o /
// out_stall_i with block_out_o, same rule.
// Configuration: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i and
// cfg_data_i. Index 0 sets decrypt mode (bit 0), indexes 1..4 hold round
// keys 0..3, 4..7, 8..11, 12..15, key 4k in the low 16 bits. Other indexes
// are ignored. Write configuration only while the pipeline is empty.
// The datapath is a chain of Rounds cells (8), one round each, every cell
// with its own register. A block taken passes through the cell registers in
// order to block_out_o; the chain takes one block per cycle unless it stalls.
// When the receiver stalls, each cell holds its block; the chain keeps
// filling until every cell is full, then in_stall_o rises.
// Reset empties all cells, clears decrypt mode and zeroes all keys.
module spn_block_cipher_16bit_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spn_pkg::KeyRegW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [spn_pkg::BlockW-1:0]    block_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spn_pkg::BlockW-1:0]    block_out_o
);
  import spn_pkg::*;

  logic                 mode_q;
  logic [KeyRegW-1:0]   keys_q [KeyRegs];

  logic                 vld   [Rounds];
  logic                 rdy   [Rounds];
  logic                 take  [Rounds];
  block_t               blk   [Rounds];
  round_cfg_t           rcfg  [Rounds];
  logic [Rounds-1:0]    vld_vec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      for (int k = 0; k < KeyRegs; k++) begin
        keys_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMode:  mode_q    <= cfg_data_i[0];
        CfgKeys0: keys_q[0] <= cfg_data_i;
        CfgKeys1: keys_q[1] <= cfg_data_i;
        CfgKeys2: keys_q[2] <= cfg_data_i;
        CfgKeys3: keys_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar r = 0; r < Rounds; r++) begin : g_cell
    localparam int unsigned EncK = r;
    localparam int unsigned DecK = Rounds - 1 - r;

    assign rcfg[r].decrypt = mode_q;
    assign rcfg[r].key = mode_q
      ? keys_q[DecK / KeysPerReg][BlockW * (DecK % KeysPerReg) +: BlockW]
      : keys_q[EncK / KeysPerReg][BlockW * (EncK % KeysPerReg) +: BlockW];
    assign vld_vec[r] = vld[r];

    if (r == Rounds - 1) begin : g_last
      assign take[r] = !out_stall_i;
    end else begin : g_mid
      assign take[r] = rdy[r+1];
    end

    if (r == 0) begin : g_first
      spn_round_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .cfg_i      (rcfg[r]),
        .in_valid_i (in_valid_i),
        .in_block_i (block_in_i),
        .ready_o    (rdy[r]),
        .valid_o    (vld[r]),
        .block_o    (blk[r]),
        .out_take_i (take[r])
      );
    end else begin : g_next
      spn_round_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .cfg_i      (rcfg[r]),
        .in_valid_i (vld[r-1]),
        .in_block_i (blk[r-1]),
        .ready_o    (rdy[r]),
        .valid_o    (vld[r]),
        .block_o    (blk[r]),
        .out_take_i (take[r])
      );
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld[Rounds-1];
  assign block_out_o = blk[Rounds-1];

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !(out_valid_o && !out_stall_i)
    |=> $countones(vld_vec) == $past($countones(vld_vec)) + 1)
    else $error("request count did not grow on accept");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o) && out_valid_o && !out_stall_i
    |=> $countones(vld_vec) + 1 == $past($countones(vld_vec)))
    else $error("request count did not shrink on delivery");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> &vld_vec)
    else $error("input stalled with a free cell");

endmodule

FILE: design/spn_round_cell.sv
// One pipeline cell: applies a single cipher round and holds the result.
module spn_round_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spn_pkg::round_cfg_t cfg_i,
  input  logic                in_valid_i,
  input  spn_pkg::block_t     in_block_i,
  output logic                ready_o,
  output logic                valid_o,
  output spn_pkg::block_t     block_o,
  input  logic                out_take_i
);
  import spn_pkg::*;

  logic   vld_q, vld_d;
  block_t blk_q;

  assign ready_o = !vld_q || out_take_i;
  assign vld_d   = ready_o ? in_valid_i : vld_q;
  assign valid_o = vld_q;
  assign block_o = blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_o) begin
      blk_q <= round_fn(in_block_i, cfg_i);
    end
  end

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !out_take_i |=> vld_q && $stable(blk_q))
    else $error("cell lost or changed a blocked request");
  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q && !in_valid_i |=> !vld_q)
    else $error("cell became valid without input");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q && in_valid_i |=> vld_q)
    else $error("free cell dropped a request");

endmodule

FILE: verif/spn_block_cipher_16bit_unit_tb.sv
// Self-checking testbench for the 16-bit SPN cipher unit, encrypt and decrypt.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spn_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemsPerPhase = 240;
  localparam int unsigned RandPhases    = 8;
  localparam logic [CfgIdxW-1:0] NoRegFirst = CfgIdxW'(CfgKeys3) + CfgIdxW'(1);
  localparam int unsigned NoRegCount = 2 ** CfgIdxW - NoRegFirst;

  localparam bit [3:0] EncSbox [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };
  localparam bit [3:0] DecSbox [16] = '{
    4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
    4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
  };
  localparam bit [15:0] CornerBlocks [12] = '{
    16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h00FF, 16'hFF00,
    16'h5555, 16'hAAAA, 16'h1234, 16'hF0F0, 16'h0F0F, 16'h7FFF
  };

  class cipher_scoreboard;
    bit        decrypt;
    bit [63:0] key_bank [KeyRegs];
    bit [15:0] expected_blocks [$];
    int        errors;

    function new();
      decrypt = 1'b0;
      foreach (key_bank[i]) key_bank[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(bit [CfgIdxW-1:0] idx, bit [63:0] data);
      case (idx) inside
        CfgMode: decrypt = data[0];
        CfgKeys0, CfgKeys1, CfgKeys2, CfgKeys3: key_bank[2'(idx - CfgKeys0)] = data;
        default: ;
      endcase
    endfunction

    function bit [15:0] subkey_word(int unsigned k);
      int unsigned slot;
      slot = k % 16;
      return key_bank[slot / KeysPerReg][BlockW * (slot % KeysPerReg) +: BlockW];
    endfunction

    function bit [15:0] sub_nibbles(bit [15:0] x, bit inv);
      bit [15:0] y;
      for (int n = 0; n < 4; n++) begin
        y[4*n +: 4] = inv ? DecSbox[x[4*n +: 4]] : EncSbox[x[4*n +: 4]];
      end
      return y;
    endfunction

    // positions counted from the MSB: row/column swap of a 4x4 bit matrix
    function bit [15:0] swap_bits(bit [15:0] x);
      bit [15:0] y;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          y[15 - (4*c + r)] = x[15 - (4*r + c)];
        end
      end
      return y;
    endfunction

    function bit [15:0] cipher_block(bit [15:0] b);
      bit [15:0] v;
      v = b;
      for (int unsigned r = 0; r < Rounds; r++) begin
        if (decrypt) begin
          v = sub_nibbles(swap_bits(v ^ subkey_word(Rounds - 1 - r)), 1'b1);
        end else begin
          v = swap_bits(sub_nibbles(v, 1'b0)) ^ subkey_word(r);
        end
      end
      return v;
    endfunction

    function void note_request(bit [15:0] b);
      expected_blocks.push_back(cipher_block(b));
    endfunction

    function void check_block(bit [15:0] got);
      bit [15:0] want;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected block_out expected none actual %h", $time, got);
        errors++;
      end else begin
        want = expected_blocks.pop_front();
        if (got !== want) begin
          $display("%0t: block_out mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [KeyRegW-1:0]  cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [BlockW-1:0]   block_in_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [BlockW-1:0]   block_out_o;

  cipher_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  spn_block_cipher_16bit_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .block_in_i  (block_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .block_out_o (block_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_block(block_out_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[spn_block_cipher_16bit_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyRegW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic load_setting(input logic [KeyRegW-1:0] mode_word,
                              input logic [KeyRegW-1:0] keys [KeyRegs]);
    logic [CfgIdxW-1:0] junk_idx;
    junk_idx = NoRegFirst + CfgIdxW'($urandom_range(0, NoRegCount - 1));
    write_reg(junk_idx, {$urandom(), $urandom()});
    write_reg(CfgMode, mode_word);
    write_reg(CfgKeys0, keys[0]);
    write_reg(CfgKeys1, keys[1]);
    write_reg(CfgKeys2, keys[2]);
    write_reg(CfgKeys3, keys[3]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_block(input logic [BlockW-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    block_in_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(b);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [KeyRegW-1:0] keys [KeyRegs];
    logic [KeyRegW-1:0] mode_word;
    logic [BlockW-1:0]  b;

    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    block_in_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: encrypt, all keys zero
    foreach (CornerBlocks[i]) send_block(CornerBlocks[i]);
    wait_drained();

    // all-ones keys, decrypt selected by a mode word with every bit set
    foreach (keys[i]) keys[i] = '1;
    load_setting('1, keys);
    foreach (CornerBlocks[i]) send_block(CornerBlocks[i]);
    wait_drained();

    for (int p = 0; p < RandPhases; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      foreach (keys[i]) begin
        if (p == 3) begin
          keys[i] = (i % 2) ? '1 : '0;
        end else begin
          keys[i] = {$urandom(), $urandom()};
        end
      end
      mode_word = {$urandom(), $urandom()};
      mode_word[0] = p[0];
      load_setting(mode_word, keys);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(15) == 0) begin
          b = CornerBlocks[$urandom_range(0, 11)];
        end else begin
          b = BlockW'($urandom_range(0, 16'hFFFF));
        end
        send_block(b);
      end
      wait_drained();
    end

    stall_pct = 0;
    repeat (Rounds + 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[spn_block_cipher_16bit_unit] OK");
    end else begin
      $display("[spn_block_cipher_16bit_unit] ERROR");
    end
    $finish;
  end

endmodule
